### hdl/tlg_pkg.sv
// Shared constants and types for the toroidal life generation block.
package tlg_pkg;

  localparam int unsigned GRID_WIDTH_DEF  = 16;
  localparam int unsigned GRID_HEIGHT_DEF = 16;

  localparam int unsigned CELL_W  = 8;
  localparam int unsigned COORD_W = 6;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned NBR_N   = 8;
  localparam int unsigned CNT_W   = 4;

  // Conway rule B3/S23.
  localparam logic [CNT_W-1:0] BIRTH_COUNT = CNT_W'(3);
  localparam logic [CNT_W-1:0] STAY_COUNT  = CNT_W'(2);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE    = 2'd0,
    OP_GENERATE = 2'd1,
    OP_READ     = 2'd2,
    OP_SPARE    = 2'd3
  } op_e;

endpackage

### hdl/tlg_ram.sv
// Generic RAM with one write port and two registered read ports.
module tlg_ram
  import tlg_pkg::*;
#(
  parameter int unsigned WIDTH = CELL_W,
  parameter int unsigned DEPTH = GRID_WIDTH_DEF * GRID_HEIGHT_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### hdl/tlg_rule.sv
// Cell update unit: neighbor count and the birth/survival rule for one cell.
module tlg_rule
  import tlg_pkg::*;
(
  input  logic [NBR_N-1:0]  nbr_i,
  input  logic [CELL_W-1:0] cell_i,
  input  logic [CELL_W-1:0] hue_i,
  output logic [CELL_W-1:0] cell_o
);

  logic [CNT_W-1:0] count;
  logic             alive;
  logic             lives;

  always_comb begin
    count = '0;
    for (int i = 0; i < NBR_N; i++) begin
      count = count + CNT_W'(nbr_i[i]);
    end
  end

  assign alive = (cell_i != '0);
  assign lives = (count == BIRTH_COUNT) || (alive && (count == STAY_COUNT));

  // A survivor keeps its hue; a newborn takes the hue of this generation.
  always_comb begin
    if (!lives) begin
      cell_o = '0;
    end else if (alive) begin
      cell_o = cell_i;
    end else begin
      cell_o = hue_i;
    end
  end

endmodule

### hdl/toroidal_life_generation.sv
// Top level: request sequencer, generation sweep with row buffers, two grid buffers.
//
// After reset the block clears both grid buffers, one cell per cycle, and keeps
// busy_o high while it clears. A request is taken when start_i is high and busy_o
// is low; its result appears on done_o for one cycle and must be sampled then,
// since it is not held. A generation sweep reads the current buffer one cell per
// cycle, first three rows into the row buffers and then every row once more as
// each cell passes the shared rule unit and is written to the other buffer.
// busy_o stays high until the request has been answered.
module toroidal_life_generation
  import tlg_pkg::*;
#(
  parameter int unsigned GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int unsigned GRID_HEIGHT = GRID_HEIGHT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [OP_W-1:0]    operation_i,
  input  logic [COORD_W-1:0] col_i,
  input  logic [COORD_W-1:0] row_i,
  input  logic [CELL_W-1:0]  cell_in_i,
  output logic               done_o,
  output logic [CELL_W-1:0]  cell_out_o,
  output logic [CELL_W-1:0]  generation_hue_o
);

  localparam int unsigned CELLS    = GRID_WIDTH * GRID_HEIGHT;
  localparam int unsigned ADDR_W   = $clog2(CELLS);
  localparam int unsigned COL_W    = $clog2(GRID_WIDTH);
  localparam int unsigned ROW_W    = $clog2(GRID_HEIGHT);
  localparam int unsigned PASSES   = GRID_HEIGHT + 3;
  localparam int unsigned PASS_W   = $clog2(PASSES);
  localparam int unsigned LIM_W    = COORD_W + 1;
  localparam logic [PASS_W-1:0] PRELOAD_PASSES = PASS_W'(3);
  localparam logic [PASS_W-1:0] LAST_PASS      = PASS_W'(PASSES - 1);
  localparam logic [COL_W-1:0]  LAST_COL       = COL_W'(GRID_WIDTH - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW       = ROW_W'(GRID_HEIGHT - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR      = ADDR_W'(CELLS - 1);
  localparam logic [LIM_W-1:0]  COL_LIM        = LIM_W'(GRID_WIDTH);
  localparam logic [LIM_W-1:0]  ROW_LIM        = LIM_W'(GRID_HEIGHT);
  localparam logic [CELL_W-1:0] HUE_MAX        = '1;
  localparam logic [CELL_W-1:0] HUE_FIRST      = CELL_W'(1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_WRITE = 6'b000100,
    S_GEN   = 6'b001000,
    S_READ  = 6'b010000,
    S_RESP  = 6'b100000
  } state_e;

  function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    return ADDR_W'(ADDR_W'(r) * ADDR_W'(GRID_WIDTH)) + ADDR_W'(c);
  endfunction

  state_e state_q, state_d;

  // Request registers.
  logic [COORD_W-1:0] col_q, col_d;
  logic [COORD_W-1:0] row_q, row_d;
  logic [CELL_W-1:0]  cell_in_q, cell_in_d;
  logic               in_range_q, in_range_d;

  logic               cur_sel_q, cur_sel_d;
  logic [CELL_W-1:0]  hue_q, hue_d;
  logic               done_q, done_d;
  logic [CELL_W-1:0]  cell_out_q, cell_out_d;
  logic [ADDR_W-1:0]  clr_addr_q, clr_addr_d;

  // Sweep issue stage.
  logic [COL_W-1:0]   col1_q, col1_d;
  logic [PASS_W-1:0]  pass_q, pass_d;
  logic [ROW_W-1:0]   ld_row_q, ld_row_d;
  logic [ROW_W-1:0]   cmp_row_q, cmp_row_d;
  logic               iss_done_q, iss_done_d;
  logic               issue;

  // Sweep update stage, in the cycle after the read is issued.
  logic               s2_vld_q;
  logic [COL_W-1:0]   s2_col_q;
  logic [ROW_W-1:0]   s2_row_q;
  logic               s2_cmp_q;
  logic               s2_last_q;
  logic               s2_end_q;

  // Live bits of the rows above, at and below the row in work, and the row loading.
  logic [GRID_WIDTH-1:0] up_q, mid_q, dn_q, nx_q;
  logic [GRID_WIDTH-1:0] nx_new;

  logic [COL_W-1:0]   cm1, cp1;
  logic [NBR_N-1:0]   nbr;
  logic [CELL_W-1:0]  next_cell;
  logic [CELL_W-1:0]  src_a, src_b;
  logic [ADDR_W-1:0]  req_addr;

  logic               we_a, we_b;
  logic [ADDR_W-1:0]  wr_addr;
  logic [CELL_W-1:0]  wr_data;
  logic [ADDR_W-1:0]  rd_addr_a, rd_addr_b;
  logic [CELL_W-1:0]  ga_rd_a, ga_rd_b, gb_rd_a, gb_rd_b;

  assign req_addr = cell_addr(row_q[ROW_W-1:0], col_q[COL_W-1:0]);
  assign issue    = (state_q == S_GEN) && !iss_done_q;

  assign rd_addr_a = (state_q == S_READ) ? req_addr : cell_addr(cmp_row_q, col1_q);
  assign rd_addr_b = cell_addr(ld_row_q, col1_q);

  assign src_a = cur_sel_q ? gb_rd_a : ga_rd_a;
  assign src_b = cur_sel_q ? gb_rd_b : ga_rd_b;

  assign cm1 = (s2_col_q == '0) ? LAST_COL : s2_col_q - COL_W'(1);
  assign cp1 = (s2_col_q == LAST_COL) ? '0 : s2_col_q + COL_W'(1);

  assign nbr = {up_q[cm1], up_q[s2_col_q], up_q[cp1],
                mid_q[cm1], mid_q[cp1],
                dn_q[cm1], dn_q[s2_col_q], dn_q[cp1]};

  always_comb begin
    nx_new           = nx_q;
    nx_new[s2_col_q] = (src_b != '0);
  end

  tlg_rule u_rule (
    .nbr_i  (nbr),
    .cell_i (src_a),
    .hue_i  (hue_q),
    .cell_o (next_cell)
  );

  always_comb begin
    state_d    = state_q;
    col_d      = col_q;
    row_d      = row_q;
    cell_in_d  = cell_in_q;
    in_range_d = in_range_q;
    cur_sel_d  = cur_sel_q;
    hue_d      = hue_q;
    done_d     = 1'b0;
    cell_out_d = cell_out_q;
    clr_addr_d = clr_addr_q;
    col1_d     = col1_q;
    pass_d     = pass_q;
    ld_row_d   = ld_row_q;
    cmp_row_d  = cmp_row_q;
    iss_done_d = iss_done_q;
    we_a       = 1'b0;
    we_b       = 1'b0;
    wr_addr    = req_addr;
    wr_data    = cell_in_q;

    unique case (state_q)
      S_CLEAR: begin
        we_a       = 1'b1;
        we_b       = 1'b1;
        wr_addr    = clr_addr_q;
        wr_data    = '0;
        clr_addr_d = clr_addr_q + ADDR_W'(1);
        if (clr_addr_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          col_d      = col_i;
          row_d      = row_i;
          cell_in_d  = cell_in_i;
          in_range_d = ({1'b0, col_i} < COL_LIM) && ({1'b0, row_i} < ROW_LIM);
          unique case (op_e'(operation_i)) inside
            OP_WRITE: begin
              state_d = S_WRITE;
            end
            OP_GENERATE: begin
              // The hue counter skips zero so that a live cell is never zero.
              hue_d      = (hue_q == HUE_MAX) ? HUE_FIRST : hue_q + CELL_W'(1);
              col1_d     = '0;
              pass_d     = '0;
              ld_row_d   = LAST_ROW;
              cmp_row_d  = '0;
              iss_done_d = 1'b0;
              state_d    = S_GEN;
            end
            OP_READ, OP_SPARE: begin
              state_d = S_READ;
            end
          endcase
        end
      end
      S_WRITE: begin
        we_a       = in_range_q && !cur_sel_q;
        we_b       = in_range_q && cur_sel_q;
        done_d     = 1'b1;
        cell_out_d = in_range_q ? cell_in_q : '0;
        state_d    = S_IDLE;
      end
      S_GEN: begin
        if (issue) begin
          if (col1_q == LAST_COL) begin
            col1_d   = '0;
            pass_d   = pass_q + PASS_W'(1);
            ld_row_d = (ld_row_q == LAST_ROW) ? '0 : ld_row_q + ROW_W'(1);
            if (pass_q >= PRELOAD_PASSES) begin
              cmp_row_d = cmp_row_q + ROW_W'(1);
            end
            if (pass_q == LAST_PASS) begin
              iss_done_d = 1'b1;
            end
          end else begin
            col1_d = col1_q + COL_W'(1);
          end
        end
        if (s2_vld_q && s2_cmp_q) begin
          we_a    = cur_sel_q;
          we_b    = !cur_sel_q;
          wr_addr = cell_addr(s2_row_q, s2_col_q);
          wr_data = next_cell;
        end
        if (s2_vld_q && s2_end_q) begin
          cur_sel_d = !cur_sel_q;
          state_d   = S_READ;
        end
      end
      S_READ: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        done_d     = 1'b1;
        cell_out_d = in_range_q ? src_a : '0;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      cur_sel_q  <= 1'b0;
      hue_q      <= HUE_FIRST;
      done_q     <= 1'b0;
      clr_addr_q <= '0;
      iss_done_q <= 1'b0;
      s2_vld_q   <= 1'b0;
      col1_q     <= '0;
      pass_q     <= '0;
      ld_row_q   <= '0;
      cmp_row_q  <= '0;
    end else begin
      state_q    <= state_d;
      cur_sel_q  <= cur_sel_d;
      hue_q      <= hue_d;
      done_q     <= done_d;
      clr_addr_q <= clr_addr_d;
      iss_done_q <= iss_done_d;
      s2_vld_q   <= issue;
      col1_q     <= col1_d;
      pass_q     <= pass_d;
      ld_row_q   <= ld_row_d;
      cmp_row_q  <= cmp_row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q      <= col_d;
    row_q      <= row_d;
    cell_in_q  <= cell_in_d;
    in_range_q <= in_range_d;
    cell_out_q <= cell_out_d;
    s2_col_q   <= col1_q;
    s2_row_q   <= cmp_row_q;
    s2_cmp_q   <= (pass_q >= PRELOAD_PASSES);
    s2_last_q  <= (col1_q == LAST_COL);
    s2_end_q   <= (col1_q == LAST_COL) && (pass_q == LAST_PASS);
    if (s2_vld_q) begin
      // At the end of a row the window moves down by one row.
      if (s2_last_q) begin
        up_q  <= mid_q;
        mid_q <= dn_q;
        dn_q  <= nx_new;
      end else begin
        nx_q <= nx_new;
      end
    end
  end

  tlg_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_grid_a (
    .clk_i     (clk_i),
    .we_i      (we_a),
    .waddr_i   (wr_addr),
    .wdata_i   (wr_data),
    .raddr_a_i (rd_addr_a),
    .raddr_b_i (rd_addr_b),
    .rdata_a_o (ga_rd_a),
    .rdata_b_o (ga_rd_b)
  );

  tlg_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_grid_b (
    .clk_i     (clk_i),
    .we_i      (we_b),
    .waddr_i   (wr_addr),
    .wdata_i   (wr_data),
    .raddr_a_i (rd_addr_a),
    .raddr_b_i (rd_addr_b),
    .rdata_a_o (gb_rd_a),
    .rdata_b_o (gb_rd_b)
  );

  assign busy_o           = (state_q != S_IDLE);
  assign done_o           = done_q;
  assign cell_out_o       = cell_out_q;
  assign generation_hue_o = hue_q;

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for two cycles");

  a_hue_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hue_q != '0)
    else $error("hue counter reached zero");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("request taken without going busy");

  a_one_grid_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_CLEAR) |-> $onehot0({we_a, we_b}))
    else $error("both grid buffers written outside the clearing pass");

  a_sweep_end_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vld_q && s2_end_q && (state_q == S_GEN)) |=> (state_q == S_READ))
    else $error("generation sweep did not end in the response read");

endmodule

### verif/toroidal_life_generation_test.sv
// Self-checking testbench for the toroidal life generation block.
module toroidal_life_generation_test;
  import tlg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned GW          = GRID_WIDTH_DEF;
  localparam int unsigned GH          = GRID_HEIGHT_DEF;
  localparam int unsigned GEN_LATENCY = (GH + 3) * GW + 4;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned PHASE_ITEMS = 60;

  typedef struct packed {
    logic [CELL_W-1:0] cell_val;
    logic [CELL_W-1:0] hue;
  } life_result_t;

  // Tracks both grid buffers and the hue counter, and holds the answers still owed.
  class life_scoreboard;
    logic [CELL_W-1:0] cells [2][GW*GH];
    bit                current;
    logic [CELL_W-1:0] hue;
    bit                hue_wrapped;
    life_result_t      owed_q [$];
    int unsigned       mismatches;

    function new();
      foreach (cells[b, i]) cells[b][i] = '0;
      current     = 1'b0;
      hue         = CELL_W'(1);
      hue_wrapped = 1'b0;
      mismatches  = 0;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    function int unsigned live_neighbors(int c, int r);
      int unsigned n;
      int          dr, dc, rr, cc;
      n = 0;
      for (dr = -1; dr <= 1; dr++) begin
        for (dc = -1; dc <= 1; dc++) begin
          if (dr != 0 || dc != 0) begin
            rr = (r + int'(GH) + dr) % int'(GH);
            cc = (c + int'(GW) + dc) % int'(GW);
            if (cells[current][rr * GW + cc] != '0) n++;
          end
        end
      end
      return n;
    endfunction

    function void advance_generation();
      int unsigned       n;
      int                r, c, idx;
      logic [CELL_W-1:0] v;
      bit                lives;
      hue = hue + CELL_W'(1);
      if (hue == '0) begin
        hue         = CELL_W'(1);
        hue_wrapped = 1'b1;
      end
      for (r = 0; r < int'(GH); r++) begin
        for (c = 0; c < int'(GW); c++) begin
          idx   = r * GW + c;
          n     = live_neighbors(c, r);
          v     = cells[current][idx];
          lives = (v != '0) ? (n == STAY_COUNT || n == BIRTH_COUNT) : (n == BIRTH_COUNT);
          if (!lives) cells[!current][idx] = '0;
          else if (v == '0) cells[!current][idx] = hue;
          else cells[!current][idx] = v;
        end
      end
      current = !current;
    endfunction

    function void note_request(op_e op, logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                               logic [CELL_W-1:0] value);
      bit           in_range;
      int unsigned  idx;
      life_result_t res;
      in_range = (col < GW) && (row < GH);
      idx      = in_range ? row * GW + col : 0;
      case (op)
        OP_WRITE: begin
          if (in_range) cells[current][idx] = value;
        end
        OP_GENERATE: begin
          advance_generation();
        end
        default: begin
        end
      endcase
      res.cell_val = in_range ? cells[current][idx] : '0;
      res.hue      = hue;
      owed_q.push_back(res);
    endfunction

    function void check_result(logic [CELL_W-1:0] act_cell, logic [CELL_W-1:0] gen_hue);
      life_result_t exp_res;
      if (owed_q.size() == 0) begin
        $display("%0t: result with no request waiting: cell_out %0d, generation_hue %0d",
                 $time, act_cell, gen_hue);
        mismatches++;
      end else begin
        exp_res = owed_q.pop_front();
        if (act_cell !== exp_res.cell_val) begin
          $display("%0t: cell_out expected %0d, actual %0d", $time, exp_res.cell_val,
                   act_cell);
          mismatches++;
        end
        if (gen_hue !== exp_res.hue) begin
          $display("%0t: generation_hue expected %0d, actual %0d", $time, exp_res.hue,
                   gen_hue);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               start_i     = 1'b0;
  logic [OP_W-1:0]    operation_i = OP_READ;
  logic [COORD_W-1:0] col_i       = '0;
  logic [COORD_W-1:0] row_i       = '0;
  logic [CELL_W-1:0]  cell_in_i   = '0;
  logic               busy_o;
  logic               done_o;
  logic [CELL_W-1:0]  cell_out_o;
  logic [CELL_W-1:0]  generation_hue_o;

  life_scoreboard board;
  int unsigned    cycle_count     = 0;
  int unsigned    requests_sent   = 0;
  int unsigned    sender_idle_pct = 0;

  toroidal_life_generation #(
    .GRID_WIDTH (GW),
    .GRID_HEIGHT(GH)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .operation_i     (operation_i),
    .col_i           (col_i),
    .row_i           (row_i),
    .cell_in_i       (cell_in_i),
    .done_o          (done_o),
    .cell_out_o      (cell_out_o),
    .generation_hue_o(generation_hue_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) board.check_result(cell_out_o, generation_hue_o);
  end

  // Mostly in range, sometimes anywhere in the 6-bit field.
  function automatic logic [COORD_W-1:0] pick_coord(int unsigned limit);
    if ($urandom_range(99) < 90) return COORD_W'($urandom_range(limit - 1));
    return COORD_W'($urandom);
  endfunction

  function automatic logic [CELL_W-1:0] pick_value();
    if ($urandom_range(99) < 75) return CELL_W'($urandom_range(255, 1));
    return '0;
  endfunction

  // Start stays high from one request to the next unless the sender idles.
  task automatic issue(op_e op, logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                       logic [CELL_W-1:0] value);
    if ($urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    start_i     <= 1'b1;
    operation_i <= op;
    col_i       <= col;
    row_i       <= row;
    cell_in_i   <= value;
    do @(posedge clk_i); while (busy_o);
    board.note_request(op, col, row, value);
    requests_sent++;
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic run_directed();
    issue(OP_READ, 6'd0, 6'd0, 8'h00);
    // Out-of-range writes must be ignored and read back as zero.
    issue(OP_WRITE, 6'd63, 6'd0, 8'hAA);
    issue(OP_WRITE, 6'd0, 6'd63, 8'h55);
    issue(OP_WRITE, 6'(GW), 6'(GH), 8'hFF);
    issue(OP_READ, 6'd63, 6'd63, 8'h00);
    issue(OP_SPARE, 6'd3, 6'd3, 8'hFF);
    // A block that wraps across all four corners.
    issue(OP_WRITE, 6'd0, 6'd0, 8'hFF);
    issue(OP_WRITE, 6'(GW - 1), 6'd0, 8'h01);
    issue(OP_WRITE, 6'd0, 6'(GH - 1), 8'h80);
    issue(OP_WRITE, 6'(GW - 1), 6'(GH - 1), 8'h7F);
    // A blinker that straddles the left and right edges.
    issue(OP_WRITE, 6'(GW - 1), 6'd8, 8'h12);
    issue(OP_WRITE, 6'd0, 6'd8, 8'h34);
    issue(OP_WRITE, 6'd1, 6'd8, 8'h56);
    issue(OP_WRITE, 6'd5, 6'd5, 8'h00);
    issue(OP_GENERATE, 6'd40, 6'd2, 8'h00);
    issue(OP_READ, 6'd0, 6'd7, 8'h00);
    issue(OP_READ, 6'(GW - 1), 6'd8, 8'h00);
    issue(OP_GENERATE, 6'd0, 6'd8, 8'hFF);
    issue(OP_READ, 6'(GW - 1), 6'd8, 8'h00);
    issue(OP_SPARE, 6'd32, 6'd40, 8'h00);
    issue(OP_READ, 6'(GW - 1), 6'(GH - 1), 8'h00);
    // Kill one corner; the remaining three cells regrow it with the new hue.
    issue(OP_WRITE, 6'(GW - 1), 6'(GH - 1), 8'h00);
    issue(OP_GENERATE, 6'd0, 6'd0, 8'h00);
    issue(OP_READ, 6'(GW - 1), 6'(GH - 1), 8'h00);
  endtask

  // Seed a local cluster, let it evolve, look around, then throw in some noise.
  task automatic run_pattern_episode();
    int unsigned base_c, base_r, n, k;
    base_c = $urandom_range(GW - 1);
    base_r = $urandom_range(GH - 1);
    n = $urandom_range(12, 3);
    for (k = 0; k < n; k++) begin
      issue(OP_WRITE, COORD_W'((base_c + $urandom_range(3)) % GW),
            COORD_W'((base_r + $urandom_range(3)) % GH), pick_value());
    end
    n = $urandom_range(10, 1);
    for (k = 0; k < n; k++) begin
      issue(OP_GENERATE, pick_coord(GW), pick_coord(GH), CELL_W'($urandom));
    end
    n = $urandom_range(3, 0);
    for (k = 0; k < n; k++) begin
      issue(OP_READ, COORD_W'((base_c + $urandom_range(3)) % GW),
            COORD_W'((base_r + $urandom_range(3)) % GH), CELL_W'($urandom));
    end
    n = $urandom_range(2, 0);
    for (k = 0; k < n; k++) begin
      issue(op_e'($urandom_range(3)), COORD_W'($urandom), COORD_W'($urandom),
            CELL_W'($urandom));
    end
  endtask

  initial begin
    int unsigned phase, target;
    board = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       sender_idle_pct = 12;
        1:       sender_idle_pct = 86;
        default: sender_idle_pct = 0;
      endcase
      if (phase == 0) run_directed();
      target = requests_sent + PHASE_ITEMS;
      while (requests_sent < target) run_pattern_episode();
      // Hold off until the block has answered everything so far.
      wait_drained();
    end
    // Keep generating until the hue counter has wrapped past its top value.
    while (!board.hue_wrapped) begin
      issue(OP_GENERATE, pick_coord(GW), pick_coord(GH), CELL_W'($urandom));
    end
    wait_drained();
    repeat (GEN_LATENCY) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
